/* src/hisf_pkg.sv */
// ----------------------------------------------------------------------------
// hisf_pkg
// Shared types and codes of the hashed integer set filter.
// ----------------------------------------------------------------------------
package hisf_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_TEST   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = CFG_IDX_W'(3);

	localparam logic signed [63:0] MIN_VALUE_RST = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] MAX_VALUE_RST = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]        HASH_MULT_RST = 64'hC6A4_A793_5BD1_E995;
	localparam logic [3:0]         SIZE_LOG2_RST = 4'd10;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [63:0] value;
	} in_word_t;

	typedef struct packed {
		logic passes;
		logic dropped;
	} out_word_t;

	typedef struct packed {
		logic signed [63:0] min_value;
		logic signed [63:0] max_value;
		logic [63:0]        hash_multiplier;
		logic [3:0]         table_size_log2;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [63:0] value;
		logic               in_range;
	} job_t;

endpackage

/* src/hisf_cfg.sv */
// ----------------------------------------------------------------------------
// hisf_cfg
// Configuration registers and the slot mask of the table size in use.
// ----------------------------------------------------------------------------
module hisf_cfg
	import hisf_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output cfg_regs_t            regs,
	output logic [$clog2(TABLE_DEPTH)-1:0] mask
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int LG_MAX = $clog2(TABLE_DEPTH + 1) - 1;

	cfg_regs_t  regs_q;
	logic [4:0] lg_eff;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_value       <= MIN_VALUE_RST;
			regs_q.max_value       <= MAX_VALUE_RST;
			regs_q.hash_multiplier <= HASH_MULT_RST;
			regs_q.table_size_log2 <= SIZE_LOG2_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_VALUE: regs_q.min_value       <= $signed(cfg_data);
				CFG_MAX_VALUE: regs_q.max_value       <= $signed(cfg_data);
				CFG_HASH_MULT: regs_q.hash_multiplier <= cfg_data;
				CFG_SIZE_LOG2: regs_q.table_size_log2 <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// size 0 acts as 1; clamp to the largest power of two that fits the table
	always_comb begin
		lg_eff = {1'b0, regs_q.table_size_log2};
		if (lg_eff == 5'd0)
			lg_eff = 5'd1;
		else if (lg_eff > 5'(LG_MAX))
			lg_eff = 5'(LG_MAX);
		for (int i = 0; i < IDX_W; i++)
			mask[i] = (5'(i) < lg_eff);
	end

endmodule

/* src/hisf_hash.sv */
// ----------------------------------------------------------------------------
// hisf_hash
// Accept stage: home slot from the product low bits and the range check.
// ----------------------------------------------------------------------------
module hisf_hash
	import hisf_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_word_t  in_word,
	input  cfg_regs_t regs,
	input  logic [$clog2(TABLE_DEPTH)-1:0] mask,
	output logic      job_vld_s1,
	output job_t      job_s1,
	output logic [$clog2(TABLE_DEPTH)-1:0] home_s1
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [IDX_W-1:0] prod_low;
	logic             in_range;

	// only the low index bits of the 64-bit product matter
	assign prod_low = IDX_W'(in_word.value[IDX_W-1:0] * regs.hash_multiplier[IDX_W-1:0]);
	assign in_range = ($signed(regs.min_value) <= $signed(in_word.value)) &&
	                  ($signed(in_word.value) <= $signed(regs.max_value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_s1 <= 1'b0;
		end else begin
			job_vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.opcode   <= in_word.opcode;
			job_s1.value    <= in_word.value;
			job_s1.in_range <= in_range;
			home_s1         <= prod_low & mask;
		end
	end

endmodule

/* src/hisf_table.sv */
// ----------------------------------------------------------------------------
// hisf_table
// Slot memory with probe sequencer, clearing sweep and result register.
// ----------------------------------------------------------------------------
module hisf_table
	import hisf_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_vld,
	input  job_t      job,
	input  logic [$clog2(TABLE_DEPTH)-1:0] home,
	input  logic [$clog2(TABLE_DEPTH)-1:0] mask,
	output logic      busy,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam int               IDX_W     = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CLEAR
	} state_t;

	state_t           state_q;
	logic             init_q;
	job_t             job_q;
	logic [IDX_W-1:0] nxt_idx_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             out_valid_q;
	out_word_t        out_word_q;

	// slot word: valid bit on top of the stored value
	logic [64:0]      mem [TABLE_DEPTH];
	logic [64:0]      rd_data_s1;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [64:0]      wr_data;

	logic slot_vld;
	logic slot_match;
	logic last_probe;
	logic probe_done;
	logic is_insert;

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	assign slot_vld   = rd_data_s1[64];
	assign slot_match = (rd_data_s1[63:0] == job_q.value);
	assign last_probe = (cnt_q == mask);
	assign is_insert  = (job_q.opcode == OP_INSERT);

	always_comb begin
		if (is_insert)
			probe_done = !slot_vld || last_probe;
		else
			probe_done = !slot_vld || slot_match || last_probe;
	end

	assign rd_addr = (state_q == ST_IDLE) ? home : nxt_idx_q;
	assign wr_en   = (state_q == ST_CLEAR) ||
	                 (state_q == ST_PROBE && is_insert && !slot_vld);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_idx_q : chk_idx_q;
	assign wr_data = {state_q != ST_CLEAR, job_q.value};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_vld) begin
						job_q     <= job;
						chk_idx_q <= home;
						nxt_idx_q <= (home + IDX_W'(1)) & mask;
						cnt_q     <= '0;
						case (job.opcode)
							OP_CLEAR: begin
								state_q   <= ST_CLEAR;
								clr_idx_q <= '0;
							end
							OP_INSERT: begin
								state_q <= ST_PROBE;
							end
							OP_TEST: begin
								if (job.in_range) begin
									state_q <= ST_PROBE;
								end else begin
									out_valid_q <= 1'b1;
									out_word_q  <= '0;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								out_word_q  <= '0;
							end
						endcase
					end
				end
				ST_PROBE: begin
					// check the slot read last cycle, read the following one
					chk_idx_q <= nxt_idx_q;
					nxt_idx_q <= (nxt_idx_q + IDX_W'(1)) & mask;
					cnt_q     <= cnt_q + IDX_W'(1);
					if (probe_done) begin
						state_q            <= ST_IDLE;
						out_valid_q        <= 1'b1;
						out_word_q.passes  <= !is_insert && slot_vld && slot_match;
						out_word_q.dropped <= is_insert && slot_vld;
					end
				end
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
						// the sweep after reset answers no word
						if (!init_q) begin
							out_valid_q <= 1'b1;
							out_word_q  <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_job_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_vld |-> state_q == ST_IDLE)
		else $error("job arrived while table busy");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> cnt_q <= mask)
		else $error("probe ran past table size");

	a_result_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_word_q.passes && out_word_q.dropped))
		else $error("result both passes and dropped");

	a_drop_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.dropped |-> job_q.opcode == OP_INSERT)
		else $error("dropped flag on a non-insert word");

endmodule

/* src/hashed_integer_set_filter.sv */
// ----------------------------------------------------------------------------
// hashed_integer_set_filter
// Linear-probing hash set of signed 64-bit values with range pre-filter.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | in_word  (opcode, value)
//  out     | output    | out_valid / out_stall | out_word (passes, dropped)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An insert or in-range test is registered in the hash stage, then the table
// probes slots in turn; the slot memory read port reads one slot a cycle.
// The next word can be taken while the result is shown, unless out_stall
// holds the result. Opcode 3 and out-of-range tests skip the probe. A clear
// sweeps the whole memory; after reset the same sweep runs with in_stall high.
// A new word is taken only while the result register is empty or draining.
// ----------------------------------------------------------------------------
module hashed_integer_set_filter
	import hisf_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	cfg_regs_t        regs;
	logic [IDX_W-1:0] mask;
	logic             accept;
	logic             job_vld_s1;
	job_t             job_s1;
	logic [IDX_W-1:0] home_s1;
	logic             busy;

	// hold off while an item is in flight or the result word is stuck
	assign in_stall = busy || job_vld_s1 || (out_valid && out_stall);
	assign accept   = in_valid && !in_stall;

	hisf_cfg #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs),
		.mask      (mask)
	);

	hisf_hash #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_word    (in_word),
		.regs       (regs),
		.mask       (mask),
		.job_vld_s1 (job_vld_s1),
		.job_s1     (job_s1),
		.home_s1    (home_s1)
	);

	hisf_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_vld   (job_vld_s1),
		.job       (job_s1),
		.home      (home_s1),
		.mask      (mask),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
